// ===== design/signed_bcd_fixed_point_add_sub_assert.svh =====
// assertion macros for the signed bcd adder/subtractor checker
// expects clk and arst_n in the scope where the macros are used
`ifndef SIGNED_BCD_FIXED_POINT_ADD_SUB_ASSERT_SVH
`define SIGNED_BCD_FIXED_POINT_ADD_SUB_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SBCD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SBCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sbcd_pkg.sv =====
// shared constants, types and digit helpers for the signed bcd adder/subtractor
// no dependencies
`timescale 1ns / 1ps

package sbcd_pkg;

	localparam int INT_DIGITS   = 16;
	localparam int FRAC_DIGITS  = 16;
	localparam int TOTAL_DIGITS = INT_DIGITS + FRAC_DIGITS;
	localparam int DIG_W        = 4;
	localparam int CELL_DIGITS  = 4;
	localparam int NUM_CELLS    = (TOTAL_DIGITS + CELL_DIGITS - 1) / CELL_DIGITS;
	localparam int PAD_DIGITS   = NUM_CELLS * CELL_DIGITS;
	localparam int VEC_W        = PAD_DIGITS * DIG_W;
	localparam int CELL_W       = CELL_DIGITS * DIG_W;
	localparam int FIELD_W      = 64;
	localparam int LEN_W        = 5;

	typedef logic [DIG_W-1:0]   digit_t;
	typedef logic [VEC_W-1:0]   dvec_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [FIELD_W-1:0] field_t;

	localparam digit_t DIGIT_MAX = 4'd9;

	typedef struct packed {
		logic sub;
		logic neg;
		len_t flen;
	} side_t;

	typedef struct packed {
		dvec_t x;
		dvec_t y;
		dvec_t r;
		logic  carry;
		side_t side;
	} word_t;

	function automatic digit_t clamp_digit(digit_t d);
		return (d > DIGIT_MAX) ? DIGIT_MAX : d;
	endfunction

endpackage

// ===== design/sbcd_if.sv =====
// valid/ready channels for request and result words
// depends on sbcd_pkg
`timescale 1ns / 1ps

interface sbcd_req_if;
	logic            valid;
	logic            ready;
	logic            op;
	sbcd_pkg::field_t a_int;
	sbcd_pkg::field_t a_frac;
	sbcd_pkg::len_t  a_frac_len;
	logic            a_neg;
	sbcd_pkg::field_t b_int;
	sbcd_pkg::field_t b_frac;
	sbcd_pkg::len_t  b_frac_len;
	logic            b_neg;

	modport source (output valid, op, a_int, a_frac, a_frac_len, a_neg,
		b_int, b_frac, b_frac_len, b_neg, input ready);
	modport sink (input valid, op, a_int, a_frac, a_frac_len, a_neg,
		b_int, b_frac, b_frac_len, b_neg, output ready);
endinterface

interface sbcd_res_if;
	logic            valid;
	logic            ready;
	sbcd_pkg::field_t res_int;
	sbcd_pkg::field_t res_frac;
	logic            res_neg;
	sbcd_pkg::len_t  int_len;
	sbcd_pkg::len_t  frac_len;
	logic            overflow;

	modport source (output valid, res_int, res_frac, res_neg, int_len, frac_len,
		overflow, input ready);
	modport sink (input valid, res_int, res_frac, res_neg, int_len, frac_len,
		overflow, output ready);
endinterface

// ===== design/sbcd_prep.sv =====
// input stage: digit unpacking, sign reduction, magnitude compare and swap
// depends on sbcd_pkg and sbcd_if
`timescale 1ns / 1ps

module sbcd_prep (
	input  logic               clk,
	input  logic               arst_n,
	sbcd_req_if.sink           req,
	output logic               word_valid,
	input  logic               word_ready,
	output sbcd_pkg::word_t    word
);

	function automatic sbcd_pkg::dvec_t unpack(sbcd_pkg::field_t ip, sbcd_pkg::field_t fp,
		sbcd_pkg::len_t flen);
		sbcd_pkg::dvec_t d;
		d = '0;
		for (int j = 1; j <= sbcd_pkg::FRAC_DIGITS; j++) begin
			if (j <= int'(flen)) begin
				d[(sbcd_pkg::FRAC_DIGITS - j) * sbcd_pkg::DIG_W +: sbcd_pkg::DIG_W] =
					sbcd_pkg::clamp_digit(fp[sbcd_pkg::FIELD_W - sbcd_pkg::DIG_W * j +:
					sbcd_pkg::DIG_W]);
			end
		end
		for (int k = 0; k < sbcd_pkg::INT_DIGITS; k++) begin
			d[(sbcd_pkg::FRAC_DIGITS + k) * sbcd_pkg::DIG_W +: sbcd_pkg::DIG_W] =
				sbcd_pkg::clamp_digit(ip[sbcd_pkg::DIG_W * k +: sbcd_pkg::DIG_W]);
		end
		return d;
	endfunction

	localparam sbcd_pkg::len_t FRAC_MAX = sbcd_pkg::len_t'(sbcd_pkg::FRAC_DIGITS);

	sbcd_pkg::len_t  la, lb;
	sbcd_pkg::dvec_t da, db;
	logic            b_neg_eff, sub, swap;
	sbcd_pkg::word_t next_word;
	sbcd_pkg::word_t word_s1;
	logic            valid_s1;
	logic            ready;

	always_comb begin
		la        = (req.a_frac_len > FRAC_MAX) ? FRAC_MAX : req.a_frac_len;
		lb        = (req.b_frac_len > FRAC_MAX) ? FRAC_MAX : req.b_frac_len;
		da        = unpack(req.a_int, req.a_frac, la);
		db        = unpack(req.b_int, req.b_frac, lb);
		b_neg_eff = req.b_neg ^ req.op;
		sub       = req.a_neg ^ b_neg_eff;
		swap      = sub && (da < db);

		next_word.x          = swap ? db : da;
		next_word.y          = swap ? da : db;
		next_word.r          = '0;
		next_word.carry      = 1'b0;
		next_word.side.sub   = sub;
		next_word.side.neg   = swap ? b_neg_eff : req.a_neg;
		next_word.side.flen  = (la > lb) ? la : lb;
	end

	assign ready     = !valid_s1 || word_ready;
	assign req.ready = ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && req.valid) begin
			word_s1 <= next_word;
		end
	end

	assign word_valid = valid_s1;
	assign word       = word_s1;

endmodule

// ===== design/sbcd_cell.sv =====
// digit cell: adds or subtracts the low group of digits with decimal carry,
// shifts operands down and the result group in at the top; depends on sbcd_pkg
`timescale 1ns / 1ps

module sbcd_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  sbcd_pkg::word_t up_word,
	output logic            dn_valid,
	input  logic            dn_ready,
	output sbcd_pkg::word_t dn_word
);

	sbcd_pkg::word_t next_word;
	sbcd_pkg::word_t word_q;
	logic            valid_q;

	always_comb begin
		logic                                c;
		sbcd_pkg::digit_t                    xd, yd;
		logic [sbcd_pkg::DIG_W:0]            t, t_adj;
		logic [sbcd_pkg::CELL_W-1:0]         grp;
		c   = up_word.carry;
		grp = '0;
		for (int i = 0; i < sbcd_pkg::CELL_DIGITS; i++) begin
			xd = up_word.x[i * sbcd_pkg::DIG_W +: sbcd_pkg::DIG_W];
			yd = up_word.y[i * sbcd_pkg::DIG_W +: sbcd_pkg::DIG_W];
			if (up_word.side.sub) begin
				t     = {1'b0, xd} - {1'b0, yd} - {4'b0000, c};
				t_adj = t + 5'd10;
				c     = t[sbcd_pkg::DIG_W];
			end else begin
				t     = {1'b0, xd} + {1'b0, yd} + {4'b0000, c};
				t_adj = t - 5'd10;
				c     = (t >= 5'd10);
			end
			grp[i * sbcd_pkg::DIG_W +: sbcd_pkg::DIG_W] =
				c ? t_adj[sbcd_pkg::DIG_W-1:0] : t[sbcd_pkg::DIG_W-1:0];
		end
		next_word       = up_word;
		next_word.x     = up_word.x >> sbcd_pkg::CELL_W;
		next_word.y     = up_word.y >> sbcd_pkg::CELL_W;
		next_word.r     = up_word.r >> sbcd_pkg::CELL_W;
		next_word.r[sbcd_pkg::VEC_W-1 -: sbcd_pkg::CELL_W] = grp;
		next_word.carry = c;
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_q <= next_word;
		end
	end

	assign dn_valid = valid_q;
	assign dn_word  = word_q;

endmodule

// ===== design/sbcd_fin.sv =====
// output stage: repacks digits, counts integer digits, fixes zero sign, flags overflow
// depends on sbcd_pkg and sbcd_if
`timescale 1ns / 1ps

module sbcd_fin (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  sbcd_pkg::word_t up_word,
	sbcd_res_if.source      res
);

	sbcd_pkg::field_t ri, rf;
	sbcd_pkg::len_t   ilen;
	logic             nonzero, ovf;

	sbcd_pkg::field_t res_int_q, res_frac_q;
	logic             res_neg_q, overflow_q, valid_q;
	sbcd_pkg::len_t   int_len_q, frac_len_q;

	always_comb begin
		sbcd_pkg::digit_t v;
		ri      = '0;
		rf      = '0;
		ilen    = sbcd_pkg::len_t'(1);
		nonzero = |up_word.r[sbcd_pkg::TOTAL_DIGITS * sbcd_pkg::DIG_W - 1:0];
		ovf     = up_word.carry ||
			((up_word.r >> (sbcd_pkg::TOTAL_DIGITS * sbcd_pkg::DIG_W)) != '0);
		for (int k = 0; k < sbcd_pkg::INT_DIGITS; k++) begin
			v = up_word.r[(sbcd_pkg::FRAC_DIGITS + k) * sbcd_pkg::DIG_W +: sbcd_pkg::DIG_W];
			ri[k * sbcd_pkg::DIG_W +: sbcd_pkg::DIG_W] = v;
			if (v != '0) begin
				ilen = sbcd_pkg::len_t'(k + 1);
			end
		end
		for (int j = 1; j <= sbcd_pkg::FRAC_DIGITS; j++) begin
			rf[sbcd_pkg::FIELD_W - sbcd_pkg::DIG_W * j +: sbcd_pkg::DIG_W] =
				up_word.r[(sbcd_pkg::FRAC_DIGITS - j) * sbcd_pkg::DIG_W +: sbcd_pkg::DIG_W];
		end
	end

	assign up_ready = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			res_int_q  <= ri;
			res_frac_q <= rf;
			res_neg_q  <= up_word.side.neg && nonzero;
			int_len_q  <= ilen;
			frac_len_q <= up_word.side.flen;
			overflow_q <= ovf;
		end
	end

	assign res.valid    = valid_q;
	assign res.res_int  = res_int_q;
	assign res.res_frac = res_frac_q;
	assign res.res_neg  = res_neg_q;
	assign res.int_len  = int_len_q;
	assign res.frac_len = frac_len_q;
	assign res.overflow = overflow_q;

endmodule

// ===== design/signed_bcd_fixed_point_add_sub.sv =====
// stages: input stage, a register per digit cell for the decimal carry chain,
// then the output register
// throughput: one word per cycle; every stage holds its word while the next is full
// reset: arst_n clears all stage valid flags; payload registers are not reset
// depends on sbcd_pkg, sbcd_if, sbcd_prep, sbcd_cell, sbcd_fin
`timescale 1ns / 1ps

module signed_bcd_fixed_point_add_sub (
	input  logic        clk,
	input  logic        arst_n,
	sbcd_req_if.sink    req,
	sbcd_res_if.source  res
);

	logic            valid_c [sbcd_pkg::NUM_CELLS+1];
	logic            ready_c [sbcd_pkg::NUM_CELLS+1];
	sbcd_pkg::word_t word_c  [sbcd_pkg::NUM_CELLS+1];

	sbcd_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.word_valid (valid_c[0]),
		.word_ready (ready_c[0]),
		.word       (word_c[0])
	);

	for (genvar g = 0; g < sbcd_pkg::NUM_CELLS; g++) begin : g_cell
		sbcd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[g]),
			.up_ready (ready_c[g]),
			.up_word  (word_c[g]),
			.dn_valid (valid_c[g+1]),
			.dn_ready (ready_c[g+1]),
			.dn_word  (word_c[g+1])
		);
	end

	sbcd_fin u_fin (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_c[sbcd_pkg::NUM_CELLS]),
		.up_ready (ready_c[sbcd_pkg::NUM_CELLS]),
		.up_word  (word_c[sbcd_pkg::NUM_CELLS]),
		.res      (res)
	);

endmodule

// ===== design/sbcd_chk.sv =====
// port-level checker for the signed bcd adder/subtractor, bound to the top level
// depends on sbcd_pkg and signed_bcd_fixed_point_add_sub_assert.svh
`timescale 1ns / 1ps
`include "signed_bcd_fixed_point_add_sub_assert.svh"

module sbcd_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input sbcd_pkg::field_t res_int,
	input sbcd_pkg::field_t res_frac,
	input logic             res_neg,
	input sbcd_pkg::len_t   int_len,
	input sbcd_pkg::len_t   frac_len,
	input logic             overflow
);

	`SBCD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_int) && $stable(res_frac) && $stable(res_neg) && $stable(int_len) && $stable(frac_len) && $stable(overflow), "result word changed while stalled")
	`SBCD_ASSERT_SAME(a_neg_nonzero, res_valid && res_neg, (res_int != '0) || (res_frac != '0), "negative zero result")
	`SBCD_ASSERT_SAME(a_int_len_range, res_valid, (int_len != '0) && (int_len <= sbcd_pkg::len_t'(sbcd_pkg::INT_DIGITS)), "integer length out of range")
	`SBCD_ASSERT_SAME(a_int_len_top, res_valid, (res_int >> {int_len, 2'b00}) == '0, "nonzero digit above integer length")

endmodule

bind signed_bcd_fixed_point_add_sub sbcd_chk u_sbcd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_int   (res.res_int),
	.res_frac  (res.res_frac),
	.res_neg   (res.res_neg),
	.int_len   (res.int_len),
	.frac_len  (res.frac_len),
	.overflow  (res.overflow)
);
